@@ rtl/psa_pkg.sv @@
// Shared codes and item types for the paged slot allocator.
package psa_pkg;

  // Operation codes carried in the input item
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RECYCLE = 2'd2;

  // Status codes carried in the result item
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_PAGE   = 2'd1;
  localparam logic [1:0] ST_RING_FULL = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_SLOTS_PER_PAGE = 2'd0;
  localparam logic [1:0] CFG_DESC_STRIDE    = 2'd1;

  localparam int CFG_W = 9;
  localparam logic [CFG_W-1:0] SLOTS_PER_PAGE_RESET = 9'd256;
  localparam logic [CFG_W-1:0] DESC_STRIDE_RESET    = 9'd32;

  // Page count and ring depth per page; the item fields are sized for these
  localparam int MAX_PAGES  = 8;
  localparam int SLOTS_MAX  = 256;
  localparam int SLOT_W     = $clog2(SLOTS_MAX + 1);
  localparam int RING_DEPTH = MAX_PAGES * SLOTS_MAX;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] free_page;
    logic [7:0] free_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  page_index;
    logic [7:0]  slot_index;
    logic [15:0] byte_offset;
    logic        opened_page;
  } out_item_t;

  // Decision handed from the page controller to the result stage
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] page;
    logic       opened;
    logic       from_ring;
  } grant_t;

endpackage

@@ rtl/psa_ring_mem.sv @@
// Recycle ring store: one write port, one registered read port.
module psa_ring_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/psa_page_ctrl.sv @@
// Page controller: page search, per-page ring pointers and bump offsets.
module psa_page_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        commit,
  input  psa_pkg::in_item_t           item,
  input  logic [psa_pkg::CFG_W-1:0]   slots_per_page,
  output psa_pkg::grant_t             grant,
  output logic [psa_pkg::SLOT_W-1:0]  bump_slot,
  output logic                        wr_en,
  output logic [psa_pkg::RING_AW-1:0] wr_addr,
  output logic [7:0]                  wr_data,
  output logic                        rd_en,
  output logic [psa_pkg::RING_AW-1:0] rd_addr
);

  localparam int MAX_PAGES = psa_pkg::MAX_PAGES;
  localparam int SLOTS_MAX = psa_pkg::SLOTS_MAX;
  localparam int SW        = psa_pkg::SLOT_W;
  localparam int AW        = psa_pkg::RING_AW;
  localparam int PGW     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int POW     = $clog2(MAX_PAGES + 1);
  localparam int PTR_MOD = 2 * SLOTS_MAX;
  localparam int PW      = $clog2(PTR_MOD);
  localparam int RW      = (SLOTS_MAX > 1) ? $clog2(SLOTS_MAX) : 1;

  logic [POW-1:0] pages_open, pages_open_next;
  logic [SW-1:0]  bump_offset    [MAX_PAGES];
  logic [SW-1:0]  bump_offset_next [MAX_PAGES];
  logic [PW-1:0]  ring_head      [MAX_PAGES];
  logic [PW-1:0]  ring_head_next [MAX_PAGES];
  logic [PW-1:0]  ring_ready_end [MAX_PAGES];
  logic [PW-1:0]  ring_ready_end_next [MAX_PAGES];
  logic [PW-1:0]  ring_tail      [MAX_PAGES];
  logic [PW-1:0]  ring_tail_next [MAX_PAGES];

  logic [SW-1:0]        eff_slots;
  logic [MAX_PAGES-1:0] has_room;
  logic                 found;
  logic [PGW-1:0]       found_page;
  logic                 wr_req, rd_req;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    if (int'(p) == PTR_MOD - 1) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_addr(input logic [PGW-1:0] pg,
                                               input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (int'(p) >= SLOTS_MAX) ? p - PW'(SLOTS_MAX) : p;
    return AW'(int'(pg) * SLOTS_MAX + int'(RW'(r)));
  endfunction

  // Clamp the page size to 1..SLOTS_MAX
  always_comb begin
    if (slots_per_page == '0) begin
      eff_slots = SW'(1);
    end else if (int'(slots_per_page) > SLOTS_MAX) begin
      eff_slots = SW'(SLOTS_MAX);
    end else begin
      eff_slots = SW'(slots_per_page);
    end
  end

  // First open page with room, lowest index wins
  always_comb begin
    found      = 1'b0;
    found_page = '0;
    for (int p = 0; p < MAX_PAGES; p++) begin
      has_room[p] = (p < int'(pages_open)) &&
                    ((ring_head[p] != ring_ready_end[p]) || (bump_offset[p] < eff_slots));
    end
    for (int p = MAX_PAGES - 1; p >= 0; p--) begin
      if (has_room[p]) begin
        found      = 1'b1;
        found_page = PGW'(p);
      end
    end
  end

  always_comb begin
    logic [PGW-1:0] alloc_page, pg;
    logic           alloc_ok;
    logic [PW-1:0]  cur_head, cur_ready_end, cur_tail;
    logic [SW-1:0]  cur_bump;
    logic [PW:0]    ring_count;
    logic           bad_free;

    pages_open_next = pages_open;
    for (int p = 0; p < MAX_PAGES; p++) begin
      bump_offset_next[p]    = bump_offset[p];
      ring_head_next[p]      = ring_head[p];
      ring_ready_end_next[p] = ring_ready_end[p];
      ring_tail_next[p]      = ring_tail[p];
    end
    grant     = '0;
    bump_slot = '0;
    wr_req    = 1'b0;
    rd_req    = 1'b0;
    wr_addr   = '0;
    rd_addr   = '0;
    wr_data   = item.free_slot;

    alloc_ok   = 1'b1;
    alloc_page = found_page;
    if (!found) begin
      alloc_page = PGW'(pages_open);
      alloc_ok   = int'(pages_open) < MAX_PAGES;
    end

    pg            = (item.op == psa_pkg::OP_FREE) ? PGW'(item.free_page) : alloc_page;
    cur_head      = ring_head[pg];
    cur_ready_end = ring_ready_end[pg];
    cur_tail      = ring_tail[pg];
    cur_bump      = bump_offset[pg];

    if (cur_tail >= cur_head) begin
      ring_count = {1'b0, cur_tail} - {1'b0, cur_head};
    end else begin
      ring_count = {1'b0, cur_tail} + (PW + 1)'(PTR_MOD) - {1'b0, cur_head};
    end
    bad_free = (int'(item.free_page) >= int'(pages_open)) ||
               (int'(item.free_page) >= MAX_PAGES) ||
               (int'(item.free_slot) >= int'(eff_slots));

    unique case (item.op)
      psa_pkg::OP_ALLOC: begin
        if (!alloc_ok) begin
          grant.status = psa_pkg::ST_NO_PAGE;
        end else begin
          grant.page = 3'(pg);
          if (!found) begin
            grant.opened    = 1'b1;
            pages_open_next = pages_open + POW'(1);
          end
          if (cur_head != cur_ready_end) begin
            grant.from_ring    = 1'b1;
            rd_req             = 1'b1;
            rd_addr            = ring_addr(pg, cur_head);
            ring_head_next[pg] = ptr_next(cur_head);
          end else begin
            bump_slot            = cur_bump;
            bump_offset_next[pg] = cur_bump + SW'(1);
          end
        end
      end
      psa_pkg::OP_FREE: begin
        if (bad_free) begin
          grant.status = psa_pkg::ST_BAD_FREE;
        end else if (int'(ring_count) >= SLOTS_MAX) begin
          grant.status = psa_pkg::ST_RING_FULL;
        end else begin
          wr_req             = 1'b1;
          wr_addr            = ring_addr(pg, cur_tail);
          ring_tail_next[pg] = ptr_next(cur_tail);
        end
      end
      psa_pkg::OP_RECYCLE: begin
        for (int p = 0; p < MAX_PAGES; p++) begin
          ring_ready_end_next[p] = ring_tail[p];
        end
      end
      default: begin
      end
    endcase
  end

  assign wr_en = commit && wr_req;
  assign rd_en = commit && rd_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_open <= '0;
      for (int p = 0; p < MAX_PAGES; p++) begin
        bump_offset[p]    <= '0;
        ring_head[p]      <= '0;
        ring_ready_end[p] <= '0;
        ring_tail[p]      <= '0;
      end
    end else if (commit) begin
      pages_open <= pages_open_next;
      for (int p = 0; p < MAX_PAGES; p++) begin
        bump_offset[p]    <= bump_offset_next[p];
        ring_head[p]      <= ring_head_next[p];
        ring_ready_end[p] <= ring_ready_end_next[p];
        ring_tail[p]      <= ring_tail_next[p];
      end
    end
  end

endmodule

@@ rtl/psa_result.sv @@
// Result stage: picks the slot, forms the byte offset and holds the result item.
module psa_result (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       grant_valid,
  input  psa_pkg::grant_t            grant,
  input  logic [psa_pkg::SLOT_W-1:0] bump_slot,
  input  logic [7:0]                 rd_data,
  input  logic [psa_pkg::CFG_W-1:0]  descriptor_stride,
  output logic                       take,
  output logic                       out_valid,
  input  logic                       out_ready,
  output psa_pkg::out_item_t         out_data
);

  localparam int SW = psa_pkg::SLOT_W;
  localparam int MW = (SW > 8) ? SW : 8;
  localparam int PRW = MW + psa_pkg::CFG_W;

  logic               b_valid;
  psa_pkg::grant_t    b_grant;
  logic [SW-1:0]      b_bump;
  logic               out_free, b_free;
  logic [MW-1:0]      slot_full;
  logic [PRW-1:0]     product;
  psa_pkg::out_item_t result;

  assign out_free = !out_valid || out_ready;
  assign b_free   = !b_valid || out_free;
  assign take     = grant_valid && b_free;

  always_comb begin
    slot_full = b_grant.from_ring ? MW'(rd_data) : MW'(b_bump);
    product   = PRW'(slot_full) * PRW'(descriptor_stride);
    result.status      = b_grant.status;
    result.page_index  = b_grant.page;
    result.slot_index  = slot_full[7:0];
    result.byte_offset = product[15:0];
    result.opened_page = b_grant.opened;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b_free) begin
        b_valid <= grant_valid;
      end
      if (out_free) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_grant <= grant;
      b_bump  <= bump_slot;
    end
    if (out_free && b_valid) begin
      out_data <= result;
    end
  end

endmodule

@@ rtl/paged_slot_allocator_deferred_free_unit.sv @@
// Top level of the paged slot allocator with deferred free.
//
// Hands out descriptor slots from up to MAX_PAGES pages of slots_per_page slots.
// An allocate takes the lowest open page with room, preferring a recycled slot
// (oldest first) over the page's bump offset, and opens the next page when no
// open page has room. A free queues the slot as pending on its page's ring; a
// recycle makes every page's pending slots reusable at once. Each accepted item
// gives exactly one result item. Timing: an item is registered on acceptance,
// the page search, pointer update and ring access then act on the held item,
// and their outcome, with the ring read data, passes through the result
// stage's buffer register into the result register. One item can be accepted
// every cycle as long as results are taken; pointer state commits in the
// decision cycle, so the next item always sees it. MAX_PAGES and SLOTS_MAX are
// fixed in the package, matching the widths of the item fields. The ring store
// (MAX_PAGES x SLOTS_MAX entries) has no reset and needs no clearing pass: only
// entries written by a free and released by a recycle are ever read.
// Configuration writes are always taken; change registers only while the block
// is idle.
module paged_slot_allocator_deferred_free_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  psa_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output psa_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [psa_pkg::CFG_W-1:0] cfg_data
);

  localparam int SW    = psa_pkg::SLOT_W;
  localparam int DEPTH = psa_pkg::RING_DEPTH;
  localparam int AW    = psa_pkg::RING_AW;

  logic [psa_pkg::CFG_W-1:0] slots_per_page;
  logic [psa_pkg::CFG_W-1:0] descriptor_stride;

  logic              item_valid;
  psa_pkg::in_item_t item;
  logic              take;

  psa_pkg::grant_t grant;
  logic [SW-1:0]   bump_slot;
  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [7:0]      wr_data, rd_data;

  // Configuration: always ready, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_per_page    <= psa_pkg::SLOTS_PER_PAGE_RESET;
      descriptor_stride <= psa_pkg::DESC_STRIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        psa_pkg::CFG_SLOTS_PER_PAGE: slots_per_page    <= cfg_data;
        psa_pkg::CFG_DESC_STRIDE:    descriptor_stride <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register: refill whenever it is empty or its item commits this cycle
  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  // Decide and commit page state for the held item
  psa_page_ctrl u_page_ctrl (
    .clk           (clk),
    .rst           (rst),
    .commit        (take),
    .item          (item),
    .slots_per_page(slots_per_page),
    .grant         (grant),
    .bump_slot     (bump_slot),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr)
  );

  // Per-page recycle rings, one region of SLOTS_MAX entries per page
  psa_ring_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ring_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Merge ring data, scale by the stride and hold the result item
  psa_result u_result (
    .clk              (clk),
    .rst              (rst),
    .grant_valid      (item_valid),
    .grant            (grant),
    .bump_slot        (bump_slot),
    .rd_data          (rd_data),
    .descriptor_stride(descriptor_stride),
    .take             (take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for the paged slot allocator with deferred free.
module testbench;

  localparam int PAGES = psa_pkg::MAX_PAGES;
  localparam int SLOTS = psa_pkg::SLOTS_MAX;
  // Generous bound: several times the slowest legal run
  localparam int LIMIT_CYCLES = 400000;
  // Op code three is spare; the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_ready;
  psa_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  psa_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [psa_pkg::CFG_W-1:0] cfg_data = '0;

  paged_slot_allocator_deferred_free_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Allocator shadow: registers, page count, bump offsets and the per-page rings
  // with their head / ready / tail pointers. Pointers are 9 bits wide so they
  // wrap modulo twice the ring depth on their own.
  // ---------------------------------------------------------------------------
  logic [psa_pkg::CFG_W-1:0] slots_reg  = psa_pkg::SLOTS_PER_PAGE_RESET;
  logic [psa_pkg::CFG_W-1:0] stride_reg = psa_pkg::DESC_STRIDE_RESET;
  int               open_pages = 0;
  int               bump_ptr   [PAGES] = '{default: 0};
  logic [7:0]       slot_ring  [PAGES][SLOTS];
  logic [8:0]       ring_head  [PAGES] = '{default: '0};
  logic [8:0]       ring_ready [PAGES] = '{default: '0};
  logic [8:0]       ring_tail  [PAGES] = '{default: '0};

  psa_pkg::in_item_t  pending_ops[$];      // items waiting for the driver
  psa_pkg::out_item_t expected_grants[$];  // results owed by the block, oldest first
  int                 mismatches = 0;

  // Append one item to the driver's queue
  function automatic void queue_op(input psa_pkg::in_item_t it);
    pending_ops = {pending_ops, it};
  endfunction

  // Clamp the slots register to the range the block honours
  function automatic int usable_slots(input int raw);
    if (raw < 1) return 1;
    if (raw > SLOTS) return SLOTS;
    return raw;
  endfunction

  function automatic bit page_has_room(input int pg);
    return (ring_head[pg] != ring_ready[pg]) ||
           (bump_ptr[pg] < usable_slots(int'(slots_reg)));
  endfunction

  // Advance the shadow by one accepted item and return the result it owes
  function automatic psa_pkg::out_item_t apply_op(input psa_pkg::in_item_t it);
    psa_pkg::out_item_t res;
    int         pg;
    bit         found;
    logic [7:0] sl;
    logic [8:0] fill;
    int         prod;
    res = '0;
    case (it.op)
      psa_pkg::OP_ALLOC: begin
        found = 1'b0;
        for (pg = 0; pg < open_pages; pg++) begin
          if (page_has_room(pg)) begin
            found = 1'b1;
            break;
          end
        end
        if (!found) begin
          if (open_pages < PAGES) begin
            pg = open_pages;
            open_pages++;
            res.opened_page = 1'b1;
            found = 1'b1;
          end else begin
            res.status = psa_pkg::ST_NO_PAGE;
          end
        end
        if (found) begin
          // Recycled slots go first, oldest first; else bump the page offset
          if (ring_head[pg] != ring_ready[pg]) begin
            sl = slot_ring[pg][ring_head[pg][7:0]];
            ring_head[pg] = ring_head[pg] + 9'd1;
          end else begin
            sl = bump_ptr[pg][7:0];
            bump_ptr[pg]++;
          end
          prod = int'(sl) * int'(stride_reg);
          res.page_index  = pg[2:0];
          res.slot_index  = sl;
          res.byte_offset = prod[15:0];
        end
      end
      psa_pkg::OP_FREE: begin
        if (int'(it.free_page) >= open_pages ||
            int'(it.free_slot) >= usable_slots(int'(slots_reg))) begin
          res.status = psa_pkg::ST_BAD_FREE;
        end else begin
          fill = ring_tail[it.free_page] - ring_head[it.free_page];
          if (fill >= 9'(SLOTS)) begin
            res.status = psa_pkg::ST_RING_FULL;
          end else begin
            slot_ring[it.free_page][ring_tail[it.free_page][7:0]] = it.free_slot;
            ring_tail[it.free_page] = ring_tail[it.free_page] + 9'd1;
          end
        end
      end
      psa_pkg::OP_RECYCLE: begin
        for (pg = 0; pg < PAGES; pg++) ring_ready[pg] = ring_tail[pg];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report(input string msg);
    if (mismatches < 100) $display("%0t  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer items in bursts of random length with random gaps. Predict
  // each item at the edge where it is accepted. Hold valid and payload until
  // the item is taken.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    logic offer;
    offer = in_valid;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_grants = {expected_grants, apply_op(in_data)};
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          in_data <= pending_ops.pop_front();
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Draw the next burst; a quarter of them follow on with no gap
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
    in_valid <= offer;
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each taken result against the oldest expectation, field by
  // field. The ready pattern switches between windows of full rate, light
  // stalls, heavy stalls and a fixed cadence; twice in the run it holds off
  // for a long stretch so the block fills and back-pressures its input.
  // ---------------------------------------------------------------------------
  int results_taken = 0;
  int hold_left     = 0;
  int window_left   = 0;
  int stall_mode    = 0;
  int rx_tick       = 0;

  always @(posedge clk) begin
    psa_pkg::out_item_t want;
    logic      rdy;
    rx_tick++;
    if (!rst && out_valid && out_ready) begin
      results_taken++;
      if (expected_grants.size() == 0) begin
        report($sformatf("result with nothing outstanding: %p", out_data));
      end else begin
        want = expected_grants.pop_front();
        if (out_data.status !== want.status)
          report($sformatf("status got %0d want %0d", out_data.status, want.status));
        if (out_data.page_index !== want.page_index)
          report($sformatf("page_index got %0d want %0d",
                           out_data.page_index, want.page_index));
        if (out_data.slot_index !== want.slot_index)
          report($sformatf("slot_index got %0d want %0d",
                           out_data.slot_index, want.slot_index));
        if (out_data.byte_offset !== want.byte_offset)
          report($sformatf("byte_offset got %0d want %0d",
                           out_data.byte_offset, want.byte_offset));
        if (out_data.opened_page !== want.opened_page)
          report($sformatf("opened_page got %0d want %0d",
                           out_data.opened_page, want.opened_page));
      end
      if (results_taken == 300 || results_taken == 500) hold_left = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      if (window_left == 0) begin
        stall_mode  = $urandom_range(0, 3);
        window_left = $urandom_range(16, 64);
      end
      window_left--;
      case (stall_mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 3) != 0);
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (rx_tick % 3 == 0);
      endcase
    end
    out_ready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic psa_pkg::in_item_t pack_op(input logic [1:0] op,
                                                input logic [2:0] pg,
                                                input logic [7:0] sl);
    psa_pkg::in_item_t it;
    it.op        = op;
    it.free_page = pg;
    it.free_slot = sl;
    return it;
  endfunction

  // Wait until the driver has nothing left and every result has come back,
  // then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_grants.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Write one register while the block is idle and track it in the shadow
  task automatic write_reg(input logic [1:0] idx,
                           input logic [psa_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == psa_pkg::CFG_SLOTS_PER_PAGE) slots_reg = val;
    else if (idx == psa_pkg::CFG_DESC_STRIDE) stride_reg = val;
  endtask

  // One random phase: set both registers, then mostly allocate / free / recycle
  // runs with random content, mixed with loose single items
  task automatic run_phase(input int spp, input int stride, input int n);
    int left;
    int k;
    int eff;
    int r;
    write_reg(psa_pkg::CFG_SLOTS_PER_PAGE, spp[psa_pkg::CFG_W-1:0]);
    write_reg(psa_pkg::CFG_DESC_STRIDE, stride[psa_pkg::CFG_W-1:0]);
    eff = usable_slots(spp);
    @(negedge clk);
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 6) begin
        k = $urandom_range(1, 6);
        repeat (k) queue_op(pack_op(psa_pkg::OP_ALLOC, 3'($urandom), 8'($urandom)));
        // Free back low slots of the low pages, with the odd stray slot
        repeat (k) queue_op(pack_op(psa_pkg::OP_FREE,
          ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(0, 7)),
          ($urandom_range(0, 9) < 9) ? 8'($urandom_range(0, eff - 1))
                                     : 8'($urandom_range(0, 255))));
        queue_op(pack_op(psa_pkg::OP_RECYCLE, 3'($urandom), 8'($urandom)));
        left -= 2 * k + 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50)
          queue_op(pack_op(psa_pkg::OP_ALLOC, 3'($urandom), 8'($urandom)));
        else if (r < 80)
          queue_op(pack_op(psa_pkg::OP_FREE, 3'($urandom), 8'($urandom)));
        else if (r < 95)
          queue_op(pack_op(psa_pkg::OP_RECYCLE, 3'($urandom), 8'($urandom)));
        else
          queue_op(pack_op(OP_UNUSED, 3'($urandom), 8'($urandom)));
        left--;
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: open page 0, free into its ring, recycle and reuse
    queue_op(pack_op(psa_pkg::OP_ALLOC,   3'd0, 8'd0));    // opens page 0
    queue_op(pack_op(psa_pkg::OP_ALLOC,   3'd0, 8'd0));
    queue_op(pack_op(psa_pkg::OP_FREE,    3'd0, 8'd1));
    queue_op(pack_op(psa_pkg::OP_FREE,    3'd0, 8'd255));  // top slot
    queue_op(pack_op(psa_pkg::OP_FREE,    3'd7, 8'd0));    // page not open yet
    queue_op(pack_op(psa_pkg::OP_ALLOC,   3'd0, 8'd0));    // frees still pending
    queue_op(pack_op(psa_pkg::OP_RECYCLE, 3'd0, 8'd0));
    queue_op(pack_op(psa_pkg::OP_ALLOC,   3'd0, 8'd0));    // oldest recycled slot
    queue_op(pack_op(psa_pkg::OP_ALLOC,   3'd0, 8'd0));    // slot 255 from the ring
    queue_op(pack_op(psa_pkg::OP_ALLOC,   3'd0, 8'd0));    // back to bumping
    queue_op(pack_op(OP_UNUSED,           3'd7, 8'd255));  // spare op, all fields high
    wait_idle();

    // One slot per page: open every remaining page, then run out of pages
    write_reg(psa_pkg::CFG_SLOTS_PER_PAGE, 9'd1);
    write_reg(psa_pkg::CFG_DESC_STRIDE, 9'd256);
    @(negedge clk);
    repeat (8) queue_op(pack_op(psa_pkg::OP_ALLOC, 3'd0, 8'd0));
    queue_op(pack_op(psa_pkg::OP_FREE,    3'd1, 8'd1));    // slot beyond the page
    queue_op(pack_op(psa_pkg::OP_FREE,    3'd1, 8'd0));
    queue_op(pack_op(psa_pkg::OP_ALLOC,   3'd0, 8'd0));    // nothing usable yet
    queue_op(pack_op(psa_pkg::OP_RECYCLE, 3'd0, 8'd0));
    queue_op(pack_op(psa_pkg::OP_ALLOC,   3'd0, 8'd0));
    wait_idle();

    run_phase(3, 17, 50);
    run_phase(0, 511, 30);      // slots below range clamp to one
    run_phase(256, 511, 40);    // large offsets wrap to 16 bits

    // Flood one ring well past its depth, then release the lot
    @(negedge clk);
    repeat (262) queue_op(pack_op(psa_pkg::OP_FREE, 3'd3, 8'($urandom)));
    queue_op(pack_op(psa_pkg::OP_RECYCLE, 3'($urandom), 8'($urandom)));
    wait_idle();

    run_phase(2, 100, 50);      // tiny pages drain the flooded ring
    run_phase(511, 1, 30);      // slots above range clamp to the maximum
    run_phase(5, 256, 40);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/psa_pkg.sv
rtl/psa_ring_mem.sv
rtl/psa_page_ctrl.sv
rtl/psa_result.sv
rtl/paged_slot_allocator_deferred_free_unit.sv
tb/testbench.sv
